// ===== design/two_axis_pid_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-axis PID tracker
// Shared concurrent assertion forms used by the tracker modules.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_PID_TRACKER_DEFINES_SVH
`define TWO_AXIS_PID_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TPT_ASSERT_IMPL(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tracker assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TPT_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tracker assertion failed");

`endif

// ===== design/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-axis PID tracker package
// Widths, register codes, stage types and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

   localparam int COORD_BITS    = 9;
   localparam int INTEGRAL_BITS = 16;
   localparam int GAIN_BITS     = 8;
   localparam int OUT_BITS      = 24;
   localparam int ERR_BITS      = COORD_BITS + 1;
   localparam int DIFF_BITS     = COORD_BITS + 2;

   localparam int PROD_BITS = GAIN_BITS + 1 +
                              ((INTEGRAL_BITS > DIFF_BITS) ? INTEGRAL_BITS : DIFF_BITS);
   localparam int SUM_BITS  = (PROD_BITS + 2 > OUT_BITS + 1) ? PROD_BITS + 2 : OUT_BITS + 1;

   localparam int CSR_DATA_BITS  = (COORD_BITS > GAIN_BITS) ? COORD_BITS : GAIN_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int IN_DATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int OUT_DATA_BITS  = ((2 * OUT_BITS + 7) / 8) * 8;

   localparam logic [COORD_BITS-1:0] CENTER_X_RESET = COORD_BITS'(80);
   localparam logic [COORD_BITS-1:0] CENTER_Y_RESET = COORD_BITS'(60);
   localparam logic [GAIN_BITS-1:0]  KP_PAN_RESET   = GAIN_BITS'(32);
   localparam logic [GAIN_BITS-1:0]  KI_PAN_RESET   = GAIN_BITS'(10);
   localparam logic [GAIN_BITS-1:0]  KD_PAN_RESET   = GAIN_BITS'(38);
   localparam logic [GAIN_BITS-1:0]  KP_TILT_RESET  = GAIN_BITS'(26);
   localparam logic [GAIN_BITS-1:0]  KI_TILT_RESET  = GAIN_BITS'(8);
   localparam logic [GAIN_BITS-1:0]  KD_TILT_RESET  = GAIN_BITS'(33);

   // errors within +/- this band leave the integral alone
   localparam logic signed [ERR_BITS-1:0] DEADBAND = ERR_BITS'(2);

   localparam logic signed [SUM_BITS-1:0] SUM_OUT_HI =
      SUM_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_BITS-1:0] SUM_OUT_LO = ~SUM_OUT_HI;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_KP_PAN   = 3'd2,
      REG_KI_PAN   = 3'd3,
      REG_KD_PAN   = 3'd4,
      REG_KP_TILT  = 3'd5,
      REG_KI_TILT  = 3'd6,
      REG_KD_TILT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [ERR_BITS-1:0]      e;
      logic signed [DIFF_BITS-1:0]     d;
      logic signed [INTEGRAL_BITS-1:0] integ;
   } err_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] kp;
      logic [GAIN_BITS-1:0] ki;
      logic [GAIN_BITS-1:0] kd;
   } gain_type;

   function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] c;
      if (v > SUM_OUT_HI) begin
         c = SUM_OUT_HI;
      end else if (v < SUM_OUT_LO) begin
         c = SUM_OUT_LO;
      end else begin
         c = v;
      end
      return c[OUT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/tpt_axis_err.sv =====
// ----------------------------------------------------------------------------
// Tracker axis error stage
// Error, derivative and deadbanded saturating integral of one axis.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_axis_pid_tracker_defines.svh"

module tpt_axis_err (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [tpt_pkg::COORD_BITS-1:0] pos,
   input  logic [tpt_pkg::COORD_BITS-1:0] center,
   output tpt_pkg::err_type               result_ff
);
   import tpt_pkg::*;

   logic signed [ERR_BITS-1:0]      prev_ff;
   logic signed [ERR_BITS-1:0]      e_in;
   logic signed [DIFF_BITS-1:0]     d_in;
   logic signed [INTEGRAL_BITS-1:0] integ_ff;
   logic signed [INTEGRAL_BITS-1:0] integ_in;
   logic signed [INTEGRAL_BITS:0]   integ_sum;
   logic                            outside;

   always_comb begin
      e_in      = $signed({1'b0, pos}) - $signed({1'b0, center});
      d_in      = DIFF_BITS'(e_in) - DIFF_BITS'(prev_ff);
      outside   = (e_in > DEADBAND) || (e_in < -DEADBAND);
      integ_sum = (INTEGRAL_BITS + 1)'(integ_ff) + (INTEGRAL_BITS + 1)'(e_in);
      if (!outside) begin
         integ_in = integ_ff;
      end else if (integ_sum[INTEGRAL_BITS] != integ_sum[INTEGRAL_BITS-1]) begin
         // clamp on overflow
         integ_in = integ_sum[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS - 1){1'b0}}}
                                             : {1'b0, {(INTEGRAL_BITS - 1){1'b1}}};
      end else begin
         integ_in = integ_sum[INTEGRAL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
      end else if (advance) begin
         prev_ff  <= e_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff.e     <= e_in;
         result_ff.d     <= d_in;
         result_ff.integ <= integ_in;
      end
   end

   `TPT_ASSERT_NEXT(a_deadband_hold, clock, reset, advance && !outside, integ_ff == $past(integ_ff))
   `TPT_ASSERT_NEXT(a_state_stall, clock, reset, !advance, $stable(prev_ff) && $stable(integ_ff))
   `TPT_ASSERT_NEXT(a_integ_rises, clock, reset, advance && outside && e_in > DEADBAND, integ_ff >= $past(integ_ff))

endmodule

`default_nettype wire

// ===== design/tpt_axis_mac.sv =====
// ----------------------------------------------------------------------------
// Tracker axis multiply-accumulate
// Forms kp*e + ki*integral + kd*(e - previous e) for one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_axis_mac (
   input  tpt_pkg::err_type                    err,
   input  tpt_pkg::gain_type                   gain,
   output logic signed [tpt_pkg::SUM_BITS-1:0] sum
);
   import tpt_pkg::*;

   logic signed [GAIN_BITS:0]  kp_s;
   logic signed [GAIN_BITS:0]  ki_s;
   logic signed [GAIN_BITS:0]  kd_s;
   logic signed [SUM_BITS-1:0] p_term;
   logic signed [SUM_BITS-1:0] i_term;
   logic signed [SUM_BITS-1:0] d_term;

   always_comb begin
      kp_s   = {1'b0, gain.kp};
      ki_s   = {1'b0, gain.ki};
      kd_s   = {1'b0, gain.kd};
      p_term = SUM_BITS'(kp_s) * SUM_BITS'(err.e);
      i_term = SUM_BITS'(ki_s) * SUM_BITS'(err.integ);
      d_term = SUM_BITS'(kd_s) * SUM_BITS'(err.d);
      sum    = p_term + i_term + d_term;
   end

endmodule

`default_nettype wire

// ===== design/two_axis_pid_tracker.sv =====
// ----------------------------------------------------------------------------
// Two-axis PID tracker
// Pan and tilt PID drives from a tracked blob position.
// ----------------------------------------------------------------------------
// Each item on req carries one blob position; each produces exactly one item
// on rsp holding the pan and tilt drives, in Q.8 units and saturated to 24 bits
// signed. The pan drive is the negated PID sum of the x axis, the tilt drive the
// PID sum of the y axis. The block takes one item per cycle while rsp is not
// stalled; an item passes through the input register, then the error and
// integral stage, then the result register, to rsp. The rate is set by the
// error stage, which updates each axis' previous error and integral once per
// item. Each stage holds while the stage after it is full and stalled, so
// bubbles close up and req stays ready while the pipeline has room. Write the
// centres and gains over the csr port only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_axis_pid_tracker_defines.svh"

module two_axis_pid_tracker (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tpt_pkg::IN_DATA_BITS-1:0]    req_tdata,   // blob_x, blob_y, zero fill
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tpt_pkg::OUT_DATA_BITS-1:0]   rsp_tdata,   // pan_drive, tilt_drive
   // configuration write port
   input  logic                                csr_we,
   input  tpt_pkg::csr_index_type              csr_index,
   input  logic [tpt_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import tpt_pkg::*;

   // configuration registers
   logic [COORD_BITS-1:0] center_x_ff;
   logic [COORD_BITS-1:0] center_y_ff;
   gain_type              gain_pan_ff;
   gain_type              gain_tilt_ff;

   // input register
   logic                      s0_valid_ff;
   logic [2*COORD_BITS-1:0]   s0_data_ff;

   // error stage
   logic                      s1_valid_ff;
   err_type                   err_pan;
   err_type                   err_tilt;

   // result register
   logic                      rsp_valid_ff;
   logic [OUT_DATA_BITS-1:0]  rsp_data_ff;
   logic [OUT_DATA_BITS-1:0]  rsp_data_in;

   logic                      out_load;
   logic                      s1_load;
   logic                      s0_load;
   logic                      advance;
   logic signed [SUM_BITS-1:0] pan_sum;
   logic signed [SUM_BITS-1:0] tilt_sum;
   logic signed [SUM_BITS-1:0] pan_neg;

   // Each stage loads when empty or when its contents move on.
   always_comb begin
      out_load = !rsp_valid_ff || rsp_tready;
      s1_load  = !s1_valid_ff || out_load;
      s0_load  = !s0_valid_ff || s1_load;
      advance  = s1_load && s0_valid_ff;
   end

   assign req_tready = s0_load;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration writes; every index of the port names a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= CENTER_X_RESET;
         center_y_ff     <= CENTER_Y_RESET;
         gain_pan_ff.kp  <= KP_PAN_RESET;
         gain_pan_ff.ki  <= KI_PAN_RESET;
         gain_pan_ff.kd  <= KD_PAN_RESET;
         gain_tilt_ff.kp <= KP_TILT_RESET;
         gain_tilt_ff.ki <= KI_TILT_RESET;
         gain_tilt_ff.kd <= KD_TILT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_CENTER_X: center_x_ff     <= csr_wdata[COORD_BITS-1:0];
            REG_CENTER_Y: center_y_ff     <= csr_wdata[COORD_BITS-1:0];
            REG_KP_PAN:   gain_pan_ff.kp  <= csr_wdata[GAIN_BITS-1:0];
            REG_KI_PAN:   gain_pan_ff.ki  <= csr_wdata[GAIN_BITS-1:0];
            REG_KD_PAN:   gain_pan_ff.kd  <= csr_wdata[GAIN_BITS-1:0];
            REG_KP_TILT:  gain_tilt_ff.kp <= csr_wdata[GAIN_BITS-1:0];
            REG_KI_TILT:  gain_tilt_ff.ki <= csr_wdata[GAIN_BITS-1:0];
            REG_KD_TILT:  gain_tilt_ff.kd <= csr_wdata[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_load) begin
            s0_valid_ff <= req_tvalid;
         end
         if (s1_load) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Capture the coordinates; hold while stalled.
   always_ff @(posedge clock) begin
      if (s0_load && req_tvalid) begin
         s0_data_ff <= req_tdata[2*COORD_BITS-1:0];
      end
   end

   // Error and integral per axis; state moves only as an item passes.
   tpt_axis_err u_err_pan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pos       (s0_data_ff[COORD_BITS-1:0]),
      .center    (center_x_ff),
      .result_ff (err_pan)
   );

   tpt_axis_err u_err_tilt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pos       (s0_data_ff[2*COORD_BITS-1:COORD_BITS]),
      .center    (center_y_ff),
      .result_ff (err_tilt)
   );

   tpt_axis_mac u_mac_pan (
      .err  (err_pan),
      .gain (gain_pan_ff),
      .sum  (pan_sum)
   );

   tpt_axis_mac u_mac_tilt (
      .err  (err_tilt),
      .gain (gain_tilt_ff),
      .sum  (tilt_sum)
   );

   // Negate pan, saturate both and pack pan into the low bits.
   always_comb begin
      pan_neg     = -pan_sum;
      rsp_data_in = '0;
      rsp_data_in[OUT_BITS-1:0]          = sat_out(pan_neg);
      rsp_data_in[2*OUT_BITS-1:OUT_BITS] = sat_out(tilt_sum);
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `TPT_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid_ff, req_tready)
   `TPT_ASSERT_NEXT(a_s0_hold, clock, reset, s0_valid_ff && !s1_load, s0_valid_ff && $stable(s0_data_ff))
   `TPT_ASSERT_NEXT(a_s1_to_out, clock, reset, s1_valid_ff && out_load, rsp_valid_ff)

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Two-axis PID tracker testbench
// Streams blob positions through the tracker and predicts each drive pair.
// ----------------------------------------------------------------------------
// A predictor class keeps its own copy of the centres, gains, previous errors
// and integrals. Every accepted position is turned into an expected pan/tilt
// drive pair. Every accepted result is compared with the oldest pair.
// The run starts with a short directed list under the reset settings. It then
// goes through several register settings, including all-zero and all-maximum
// gains and centres at both ends of the range. Each setting gets random
// positions in runs: uniform, near the centre, pinned at an edge, and swinging
// edge to edge. The sender idles in bursts and the receiver stalls on its own
// pattern. A watchdog ends the run if nothing is accepted for too long.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   import tpt_pkg::*;

   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int DEADBAND_ERR  = 2;
   localparam int IDLE_LIMIT    = 2000;
   localparam int PHASE_ITEMS   = 100;
   localparam int LAST_PHASE    = 6;
   localparam int PRINT_LIMIT   = 100;
   localparam int PAN           = 0;
   localparam int TILT          = 1;

   typedef enum int {RUN_UNIFORM, RUN_NEAR, RUN_EDGE, RUN_SWING} run_kind_type;

   // -------------------------------------------------------------------------
   // Drive predictor: mirrors the tracker state and holds the expected pairs
   // -------------------------------------------------------------------------
   class drive_predictor;
      typedef struct packed {
         logic [OUT_BITS-1:0] pan;
         logic [OUT_BITS-1:0] tilt;
      } drive_pair_type;

      logic [COORD_BITS-1:0]           centre [2];
      logic [GAIN_BITS-1:0]            kp [2];
      logic [GAIN_BITS-1:0]            ki [2];
      logic [GAIN_BITS-1:0]            kd [2];
      logic signed [ERR_BITS-1:0]      last_err [2];
      logic signed [INTEGRAL_BITS-1:0] integ [2];
      drive_pair_type                  expected_drives [$];
      int                              mismatches;

      function new();
         centre[PAN]  = CENTER_X_RESET;
         centre[TILT] = CENTER_Y_RESET;
         kp[PAN]      = KP_PAN_RESET;
         ki[PAN]      = KI_PAN_RESET;
         kd[PAN]      = KD_PAN_RESET;
         kp[TILT]     = KP_TILT_RESET;
         ki[TILT]     = KI_TILT_RESET;
         kd[TILT]     = KD_TILT_RESET;
         last_err     = '{'0, '0};
         integ        = '{'0, '0};
         mismatches   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx)
            REG_CENTER_X: centre[PAN]  = v[COORD_BITS-1:0];
            REG_CENTER_Y: centre[TILT] = v[COORD_BITS-1:0];
            REG_KP_PAN:   kp[PAN]      = v[GAIN_BITS-1:0];
            REG_KI_PAN:   ki[PAN]      = v[GAIN_BITS-1:0];
            REG_KD_PAN:   kd[PAN]      = v[GAIN_BITS-1:0];
            REG_KP_TILT:  kp[TILT]     = v[GAIN_BITS-1:0];
            REG_KI_TILT:  ki[TILT]     = v[GAIN_BITS-1:0];
            REG_KD_TILT:  kd[TILT]     = v[GAIN_BITS-1:0];
            default: ;
         endcase
      endfunction

      // advance one axis and return its raw PID sum in Q.8
      function longint axis_sum(int a, logic [COORD_BITS-1:0] pos);
         longint e, d, acc, imax, imin;
         imax = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
         imin = -imax - 1;
         e = longint'(pos) - longint'(centre[a]);
         d = e - longint'(last_err[a]);
         if (e < -DEADBAND_ERR || e > DEADBAND_ERR) begin
            acc = longint'(integ[a]) + e;
            if (acc > imax) acc = imax;
            if (acc < imin) acc = imin;
            integ[a] = acc[INTEGRAL_BITS-1:0];
         end
         last_err[a] = e[ERR_BITS-1:0];
         return longint'(kp[a]) * e + longint'(ki[a]) * longint'(integ[a]) +
                longint'(kd[a]) * d;
      endfunction

      function logic [OUT_BITS-1:0] clip_drive(longint v);
         longint hi, lo;
         hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         return v[OUT_BITS-1:0];
      endfunction

      function void note_position(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
         drive_pair_type p;
         p.pan  = clip_drive(-axis_sum(PAN, x));
         p.tilt = clip_drive(axis_sum(TILT, y));
         expected_drives.push_back(p);
      endfunction

      task report_mismatch(string msg);
         // keep the log short on a badly broken block, but count everything
         if (mismatches < PRINT_LIMIT) $display("ERROR: %s", msg);
         mismatches++;
      endtask

      task check_drives(logic [OUT_DATA_BITS-1:0] data);
         drive_pair_type p;
         logic [OUT_BITS-1:0] pan_got, tilt_got;
         pan_got  = data[OUT_BITS-1:0];
         tilt_got = data[2*OUT_BITS-1:OUT_BITS];
         if (expected_drives.size() == 0) begin
            report_mismatch($sformatf("result pan=%0d tilt=%0d with nothing pending",
                                      $signed(pan_got), $signed(tilt_got)));
         end else begin
            p = expected_drives.pop_front();
            if (pan_got !== p.pan)
               report_mismatch($sformatf("pan_drive got %0d, want %0d",
                                         $signed(pan_got), $signed(p.pan)));
            if (tilt_got !== p.tilt)
               report_mismatch($sformatf("tilt_drive got %0d, want %0d",
                                         $signed(tilt_got), $signed(p.tilt)));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block signals
   // -------------------------------------------------------------------------
   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [IN_DATA_BITS-1:0]    req_tdata  = '0;   // blob_x, blob_y, zero fill
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [OUT_DATA_BITS-1:0]   rsp_tdata;         // pan_drive, tilt_drive
   logic                       csr_we     = 1'b0;
   csr_index_type              csr_index  = REG_CENTER_X;
   logic [CSR_DATA_BITS-1:0]   csr_wdata  = '0;

   drive_predictor board = new();

   // position run state for the random part
   run_kind_type run_kind  = RUN_UNIFORM;
   int           run_left  = 0;
   bit           edge_x    = 1'b0;
   bit           edge_y    = 1'b0;
   bit           swing     = 1'b0;

   // receiver stall pattern state
   int           rsp_kind  = 0;
   int           rsp_left  = 0;

   int           idle_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   two_axis_pid_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Receiver: switch between always ready, coin-flip, sparse and a fixed
   // duty pattern, each held for a random stretch of cycles
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_left == 0) begin
         rsp_kind = $urandom_range(0, 3);
         rsp_left = $urandom_range(30, 200);
      end else begin
         rsp_left = rsp_left - 1;
      end
      case (rsp_kind)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= ((rsp_left % 16) < 4);
      endcase
   end

   // check every result the moment it is taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_drives(rsp_tdata);
   end

   // watchdog: count cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------
   // Present one position and hold it until taken, then note it.
   task automatic push_position(input logic [COORD_BITS-1:0] x,
                                input logic [COORD_BITS-1:0] y);
      req_tdata  <= IN_DATA_BITS'({y, x});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_position(x, y);
   endtask

   task automatic hold_sender(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drop valid and wait for every pending result, plus the pipeline depth.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
   endtask

   function automatic logic [COORD_BITS-1:0] near_centre(input int c);
      int v;
      v = c + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic logic [COORD_BITS-1:0] at_edge(input bit high);
      int v;
      v = int'($urandom_range(0, 3));
      return high ? COORD_BITS'(COORD_MAX - v) : COORD_BITS'(v);
   endfunction

   // Pick the next position from the current run, starting a new run when due.
   task automatic pick_position(output logic [COORD_BITS-1:0] x,
                                output logic [COORD_BITS-1:0] y);
      int roll;
      if (run_left == 0) begin
         roll     = $urandom_range(0, 9);
         run_kind = (roll < 4) ? RUN_UNIFORM :
                    (roll < 6) ? RUN_NEAR    :
                    (roll < 9) ? RUN_EDGE    : RUN_SWING;
         run_left = $urandom_range(4, 60);
         edge_x   = 1'($urandom_range(0, 1));
         edge_y   = 1'($urandom_range(0, 1));
      end
      run_left--;
      case (run_kind)
         RUN_NEAR: begin
            x = near_centre(int'(board.centre[PAN]));
            y = near_centre(int'(board.centre[TILT]));
         end
         RUN_EDGE: begin
            // pin both axes at one end so the integrals run into their limits
            x = at_edge(edge_x);
            y = at_edge(edge_y);
         end
         RUN_SWING: begin
            // full-scale swings give the largest derivative terms
            x     = swing ? COORD_BITS'(COORD_MAX) : '0;
            y     = swing ? '0 : COORD_BITS'(COORD_MAX);
            swing = !swing;
         end
         default: begin
            x = COORD_BITS'($urandom_range(0, COORD_MAX));
            y = COORD_BITS'($urandom_range(0, COORD_MAX));
         end
      endcase
   endtask

   task automatic send_random(input int count);
      int sent, burst, gap;
      logic [COORD_BITS-1:0] x, y;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            pick_position(x, y);
            push_position(x, y);
            sent++;
            // now and then let the pipeline empty completely
            if ($urandom_range(0, 149) == 0) drain_results();
         end
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap != 0) hold_sender(gap);
      end
   endtask

   // Write all eight registers for one phase; only ever called when idle.
   task automatic configure_phase(input int phase);
      logic [CSR_DATA_BITS-1:0] vals [8];
      drain_results();
      case (phase)
         1: begin
            // centres at zero, gains at maximum: large positive errors
            vals[REG_CENTER_X] = '0;
            vals[REG_CENTER_Y] = '0;
            for (int i = REG_KP_PAN; i <= REG_KD_TILT; i++) vals[i] = 9'h0FF;
         end
         2: begin
            // centres at the top; gain writes carry a stray upper bit to drop
            vals[REG_CENTER_X] = 9'h1FF;
            vals[REG_CENTER_Y] = 9'h1FF;
            for (int i = REG_KP_PAN; i <= REG_KD_TILT; i++) vals[i] = 9'h1FF;
         end
         3: begin
            vals[REG_CENTER_X] = 9'($urandom_range(0, COORD_MAX));
            vals[REG_CENTER_Y] = 9'($urandom_range(0, COORD_MAX));
            for (int i = REG_KP_PAN; i <= REG_KD_TILT; i++) vals[i] = '0;
         end
         5: begin
            vals[REG_CENTER_X] = 9'h1FF;
            vals[REG_CENTER_Y] = '0;
            vals[REG_KP_PAN]   = 9'(KP_PAN_RESET);
            vals[REG_KI_PAN]   = 9'(KI_PAN_RESET);
            vals[REG_KD_PAN]   = 9'(KD_PAN_RESET);
            vals[REG_KP_TILT]  = 9'(KP_TILT_RESET);
            vals[REG_KI_TILT]  = 9'(KI_TILT_RESET);
            vals[REG_KD_TILT]  = 9'(KD_TILT_RESET);
         end
         default: begin
            for (int i = REG_CENTER_X; i <= REG_KD_TILT; i++)
               vals[i] = 9'($urandom_range(0, 511));
         end
      endcase
      for (int i = REG_CENTER_X; i <= REG_KD_TILT; i++)
         write_register(csr_index_type'(i), vals[i]);
      csr_we <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      // directed list under reset settings (centre 80, 60): zero error,
      // deadband edges at +/-2, first integrating errors at +/-3, the
      // coordinate extremes, alternating bit patterns and full swings
      logic [COORD_BITS-1:0] dir_x [20] = '{
         9'd80,  9'd82,  9'd83,  9'd78,  9'd77,  9'd0,   9'd511, 9'd0,
         9'd511, 9'd81,  9'd79,  9'd511, 9'd511, 9'd0,   9'd0,   9'd256,
         9'h0AA, 9'h155, 9'd84,  9'd80};
      logic [COORD_BITS-1:0] dir_y [20] = '{
         9'd60,  9'd62,  9'd63,  9'd58,  9'd57,  9'd0,   9'd511, 9'd511,
         9'd0,   9'd59,  9'd61,  9'd511, 9'd511, 9'd0,   9'd0,   9'd256,
         9'h155, 9'h0AA, 9'd56,  9'd60};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 20; i++) begin
         push_position(dir_x[i], dir_y[i]);
         if (i == 9) hold_sender(3);
      end
      send_random(PHASE_ITEMS - 20);

      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         configure_phase(phase);
         send_random(PHASE_ITEMS);
      end

      drain_results();
      repeat (8) @(posedge clock);

      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
